// ===== sv/aabb_triangle_overlap_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box/triangle overlap unit
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AABB_TRIANGLE_OVERLAP_UNIT_MACROS_SVH
`define AABB_TRIANGLE_OVERLAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ATOV_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("atov check failed");
`define ATOV_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(expr)) else $error("atov check failed");
`else
`define ATOV_ASSERT(lbl, prop)
`define ATOV_NEVER(lbl, expr)
`endif
`endif

// ===== sv/atov_pkg.sv =====
// ----------------------------------------------------------------------------
// atov_pkg
// Widths, number types and register codes of the box/triangle overlap unit.
// ----------------------------------------------------------------------------
package atov_pkg;

	localparam int CW     = 32;          // coordinate, Q16.16
	localparam int HW     = CW + 1;      // doubled center / half extent
	localparam int DW     = CW + 3;      // vertex relative to doubled center
	localparam int EW     = DW + 1;      // edge vector
	localparam int MW     = EW + DW;     // edge * vertex product
	localparam int AW     = EW + 1;      // |edge|
	localparam int RMW    = AW + HW;     // |edge| * half extent
	localparam int PW     = MW + 1;      // projection / radius
	localparam int NMW    = 2 * EW;      // edge * edge
	localparam int NW     = NMW + 1;     // plane normal component
	localparam int VW     = DW + 1;      // plane test corner offset
	localparam int NSPLIT = VW;          // low bits of normal in split product
	localparam int PLW    = NSPLIT + 1 + VW;
	localparam int PHW    = NW - NSPLIT + VW;
	localparam int SW     = 112;         // dot product accumulator
	localparam int NVERT  = 3;
	localparam int IDXW   = 3;

	typedef logic signed [CW-1:0]  coord_t;
	typedef logic signed [HW-1:0]  h_t;
	typedef logic signed [DW-1:0]  d_t;
	typedef logic signed [EW-1:0]  e_t;
	typedef logic signed [MW-1:0]  mul_t;
	typedef logic signed [AW-1:0]  abs_t;
	typedef logic signed [RMW-1:0] rmul_t;
	typedef logic signed [PW-1:0]  p_t;
	typedef logic signed [NMW-1:0] nmul_t;
	typedef logic signed [NW-1:0]  n_t;
	typedef logic signed [VW-1:0]  v_t;
	typedef logic signed [PLW-1:0] pl_t;
	typedef logic signed [PHW-1:0] ph_t;
	typedef logic signed [SW-1:0]  s_t;

	typedef enum logic [IDXW-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

endpackage

// ===== sv/atov_edge_axis.sv =====
// ----------------------------------------------------------------------------
// atov_edge_axis
// One edge-cross-axis separating test, three register stages deep.
// ----------------------------------------------------------------------------
module atov_edge_axis (
	input  logic            clk,
	input  logic            en,
	input  atov_pkg::e_t    a,
	input  atov_pkg::e_t    b,
	input  atov_pkg::d_t    du [atov_pkg::NVERT],
	input  atov_pkg::d_t    dw [atov_pkg::NVERT],
	input  atov_pkg::h_t    hu,
	input  atov_pkg::h_t    hw,
	output logic            sep
);

	atov_pkg::abs_t  a_abs, b_abs;
	atov_pkg::mul_t  pa_s3 [atov_pkg::NVERT];
	atov_pkg::mul_t  pb_s3 [atov_pkg::NVERT];
	atov_pkg::rmul_t ra_s3, rb_s3;
	atov_pkg::p_t    p_s4 [atov_pkg::NVERT];
	atov_pkg::p_t    rad_s4;
	atov_pkg::p_t    lo, hi;
	logic            sep_s5;

	always_comb begin
		a_abs = a[atov_pkg::EW-1] ? -atov_pkg::AW'(a) : atov_pkg::AW'(a);
		b_abs = b[atov_pkg::EW-1] ? -atov_pkg::AW'(b) : atov_pkg::AW'(b);
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < atov_pkg::NVERT; j++) begin
				pa_s3[j] <= a * du[j];
				pb_s3[j] <= b * dw[j];
			end
			ra_s3 <= a_abs * hu;
			rb_s3 <= b_abs * hw;
		end
	end

	// stage 4: projections and radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < atov_pkg::NVERT; j++)
				p_s4[j] <= atov_pkg::PW'(pa_s3[j]) - atov_pkg::PW'(pb_s3[j]);
			rad_s4 <= atov_pkg::PW'(ra_s3) + atov_pkg::PW'(rb_s3);
		end
	end

	always_comb begin
		lo = p_s4[0];
		hi = p_s4[0];
		for (int j = 1; j < atov_pkg::NVERT; j++) begin
			if (p_s4[j] < lo) lo = p_s4[j];
			if (p_s4[j] > hi) hi = p_s4[j];
		end
	end

	// stage 5: verdict
	always_ff @(posedge clk) begin
		if (en) begin
			sep_s5 <= (rad_s4 < lo) || (hi < -rad_s4);
		end
	end

	assign sep = sep_s5;

endmodule

// ===== sv/aabb_triangle_overlap_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_triangle_overlap_unit
// Separating-axis overlap test of a configured box against streamed triangles.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  ----------+-----------+------------------------------------------------
//  cfg_*     | in        | box corner register write, index + Q16.16 value
//  s_axis    | in        | one triangle, nine Q16.16 coordinates
//  m_axis    | out       | one overlap flag per triangle
//
//  One triangle can enter every cycle while the output is not stalled. The
//  nine-stage pipeline is set by the 37x36 split products of the plane test
//  and the 72-bit min/max compares of the axis tests. All stages advance
//  together; they hold when the output word is waiting and m_tready is low.
//  Reset clears the valid bits and the box to zero. Box registers must be
//  written only while no triangle is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "aabb_triangle_overlap_unit_macros.svh"

module aabb_triangle_overlap_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [atov_pkg::IDXW-1:0] cfg_index,
	input  logic [atov_pkg::CW-1:0]   cfg_data,
	// triangle in
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
	// vert_c_x, vert_c_y, vert_c_z (32 bits each, lowest first)
	input  logic [9*atov_pkg::CW-1:0] s_tdata,
	// verdict out
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// overlap in bit 0, zeros above
	output logic [7:0]                m_tdata
);

	localparam int NV = atov_pkg::NVERT;

	// box registers
	atov_pkg::coord_t box_min_q [NV];
	atov_pkg::coord_t box_max_q [NV];
	atov_pkg::h_t     c2 [NV];   // min + max (doubled center)
	atov_pkg::h_t     h  [NV];   // max - min (doubled half extent)

	// pipeline
	logic             en;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	atov_pkg::coord_t vin  [NV][NV];
	atov_pkg::d_t     d_s1 [NV][NV];
	atov_pkg::d_t     d_s2 [NV][NV];
	atov_pkg::e_t     e_s2 [NV][NV];
	logic             bsep_s2, bsep_s3, bsep_s4, bsep_s5;
	logic [NV*NV-1:0] esep;
	atov_pkg::d_t     d0_s3 [NV];
	atov_pkg::d_t     d0_s4 [NV];
	atov_pkg::nmul_t  nm1_s3 [NV];
	atov_pkg::nmul_t  nm2_s3 [NV];
	atov_pkg::n_t     n_s4 [NV];
	atov_pkg::n_t     n_s5 [NV];
	atov_pkg::v_t     vlo_s5 [NV];
	atov_pkg::v_t     vhi_s5 [NV];
	atov_pkg::pl_t    lolo_s6 [NV];
	atov_pkg::ph_t    hilo_s6 [NV];
	atov_pkg::pl_t    lohi_s6 [NV];
	atov_pkg::ph_t    hihi_s6 [NV];
	atov_pkg::s_t     tlo_s7 [NV];
	atov_pkg::s_t     thi_s7 [NV];
	atov_pkg::s_t     dlo_s8, dhi_s8;
	logic             sep_s6, sep_s7, sep_s8;
	logic             ovl_s9;
	logic             bsep;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (atov_pkg::cfg_reg_t'(cfg_index))
				atov_pkg::REG_MIN_X: box_min_q[0] <= cfg_data;
				atov_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data;
				atov_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data;
				atov_pkg::REG_MAX_X: box_max_q[0] <= cfg_data;
				atov_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data;
				atov_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;   // unknown index: ignored
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < NV; k++) begin
			c2[k] = atov_pkg::HW'(box_min_q[k]) + atov_pkg::HW'(box_max_q[k]);
			h[k]  = atov_pkg::HW'(box_max_q[k]) - atov_pkg::HW'(box_min_q[k]);
		end
	end

	// ---------------- flow control ----------------
	// whole pipe moves unless the output word is stuck
	assign en       = !v_s9 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s9;
	assign m_tdata  = {7'd0, ovl_s9};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ---------------- stage 1: vertices about doubled center ----------------
	always_comb begin
		for (int i = 0; i < NV; i++)
			for (int k = 0; k < NV; k++)
				vin[i][k] = $signed(s_tdata[(i*NV+k)*atov_pkg::CW +: atov_pkg::CW]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NV; i++)
				for (int k = 0; k < NV; k++)
					d_s1[i][k] <= (atov_pkg::DW'(vin[i][k]) <<< 1) - atov_pkg::DW'(c2[k]);
		end
	end

	// ---------------- stage 2: edges, box-axis tests ----------------
	always_comb begin
		atov_pkg::d_t lo, hi;
		bsep = 1'b0;
		for (int k = 0; k < NV; k++) begin
			lo = d_s1[0][k];
			hi = d_s1[0][k];
			for (int i = 1; i < NV; i++) begin
				if (d_s1[i][k] < lo) lo = d_s1[i][k];
				if (d_s1[i][k] > hi) hi = d_s1[i][k];
			end
			if (lo > atov_pkg::DW'(h[k]) || hi < -atov_pkg::DW'(h[k]))
				bsep = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++) begin
				e_s2[0][k] <= atov_pkg::EW'(d_s1[1][k]) - atov_pkg::EW'(d_s1[0][k]);
				e_s2[1][k] <= atov_pkg::EW'(d_s1[2][k]) - atov_pkg::EW'(d_s1[1][k]);
				e_s2[2][k] <= atov_pkg::EW'(d_s1[0][k]) - atov_pkg::EW'(d_s1[2][k]);
			end
			d_s2    <= d_s1;
			bsep_s2 <= bsep;
		end
	end

	// ---------------- stages 3-5: edge-cross-axis tests, one per edge and axis ----------------
	for (genvar gi = 0; gi < NV; gi++) begin : g_edge
		for (genvar gk = 0; gk < NV; gk++) begin : g_axis
			localparam int U = (gk + 1) % NV;
			localparam int W = (gk + 2) % NV;
			atov_pkg::d_t du [NV];
			atov_pkg::d_t dw [NV];
			always_comb begin
				for (int j = 0; j < NV; j++) begin
					du[j] = d_s2[j][U];
					dw[j] = d_s2[j][W];
				end
			end
			atov_edge_axis u_axis (
				.clk (clk),
				.en  (en),
				.a   (e_s2[gi][W]),
				.b   (e_s2[gi][U]),
				.du  (du),
				.dw  (dw),
				.hu  (h[U]),
				.hw  (h[W]),
				.sep (esep[gi*NV+gk])
			);
		end
	end

	// ---------------- stages 3-5: plane normal and corner offsets ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++) begin
				nm1_s3[k] <= e_s2[0][(k+1)%NV] * e_s2[1][(k+2)%NV];
				nm2_s3[k] <= e_s2[0][(k+2)%NV] * e_s2[1][(k+1)%NV];
				d0_s3[k]  <= d_s2[0][k];
			end
			bsep_s3 <= bsep_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++)
				n_s4[k] <= atov_pkg::NW'(nm1_s3[k]) - atov_pkg::NW'(nm2_s3[k]);
			d0_s4   <= d0_s3;
			bsep_s4 <= bsep_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++) begin
				// positive normal: near corner is -h, far corner +h
				if (!n_s4[k][atov_pkg::NW-1] && (n_s4[k] != '0)) begin
					vlo_s5[k] <= -atov_pkg::VW'(h[k]) - atov_pkg::VW'(d0_s4[k]);
					vhi_s5[k] <=  atov_pkg::VW'(h[k]) - atov_pkg::VW'(d0_s4[k]);
				end else begin
					vlo_s5[k] <=  atov_pkg::VW'(h[k]) - atov_pkg::VW'(d0_s4[k]);
					vhi_s5[k] <= -atov_pkg::VW'(h[k]) - atov_pkg::VW'(d0_s4[k]);
				end
			end
			n_s5    <= n_s4;
			bsep_s5 <= bsep_s4;
		end
	end

	// ---------------- stage 6: split normal * offset products ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++) begin
				lolo_s6[k] <= $signed({1'b0, n_s5[k][atov_pkg::NSPLIT-1:0]}) * vlo_s5[k];
				hilo_s6[k] <= $signed(n_s5[k][atov_pkg::NW-1:atov_pkg::NSPLIT]) * vlo_s5[k];
				lohi_s6[k] <= $signed({1'b0, n_s5[k][atov_pkg::NSPLIT-1:0]}) * vhi_s5[k];
				hihi_s6[k] <= $signed(n_s5[k][atov_pkg::NW-1:atov_pkg::NSPLIT]) * vhi_s5[k];
			end
			sep_s6 <= bsep_s5 || (|esep);
		end
	end

	// ---------------- stage 7: recombine partial products ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NV; k++) begin
				tlo_s7[k] <= (atov_pkg::SW'(hilo_s6[k]) <<< atov_pkg::NSPLIT)
					+ atov_pkg::SW'(lolo_s6[k]);
				thi_s7[k] <= (atov_pkg::SW'(hihi_s6[k]) <<< atov_pkg::NSPLIT)
					+ atov_pkg::SW'(lohi_s6[k]);
			end
			sep_s7 <= sep_s6;
		end
	end

	// ---------------- stage 8: dot products ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			dlo_s8 <= tlo_s7[0] + tlo_s7[1] + tlo_s7[2];
			dhi_s8 <= thi_s7[0] + thi_s7[1] + thi_s7[2];
			sep_s8 <= sep_s7;
		end
	end

	// ---------------- stage 9: output word ----------------
	// plane separates when near corner is above it or far corner below it
	always_ff @(posedge clk) begin
		if (en) begin
			ovl_s9 <= !(sep_s8 || (!dlo_s8[atov_pkg::SW-1] && (dlo_s8 != '0))
				|| dhi_s8[atov_pkg::SW-1]);
		end
	end

	// ---------------- checks ----------------
	`ATOV_ASSERT(a_accept_fills_s1, s_tvalid && s_tready |=> v_s1)
	`ATOV_ASSERT(a_s8_reaches_out, v_s8 && en |=> m_tvalid)
	`ATOV_NEVER(a_stall_needs_word, !s_tready && !m_tvalid)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box/triangle overlap unit: streams triangles
// against several box settings and checks each verdict against an exact
// separating-axis predictor kept in wide signed integers.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic signed [191:0] wide_t;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 14;     // pipeline is 9 deep

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [atov_pkg::IDXW-1:0]   cfg_index = '0;
	logic [atov_pkg::CW-1:0]     cfg_data = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [9*atov_pkg::CW-1:0]   s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [7:0]                  m_tdata;

	aabb_triangle_overlap_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// box shadow, as written through the config port
	atov_pkg::coord_t box_lo[3];
	atov_pkg::coord_t box_hi[3];

	bit     verdict_q[$];    // expected overlap flags, oldest first
	int     errors = 0;
	int     tri_sent = 0;
	int     verdicts_seen = 0;
	int     hits_seen = 0;
	int     box_writes = 0;
	int     idle_cnt = 0;
	bit     no_gaps = 0;     // stretch with no idling on either side

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic wide_t wabs(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// one edge x box-axis test: 1 when the axis separates
	function automatic bit edge_axis_cuts(wide_t a, wide_t b, wide_t du[3], wide_t dw[3],
			wide_t hu, wide_t hw);
		wide_t p, lo, hi, rad;
		lo = a * du[0] - b * dw[0];
		hi = lo;
		for (int i = 1; i < 3; i++) begin
			p = a * du[i] - b * dw[i];
			if (p < lo) lo = p;
			if (p > hi) hi = p;
		end
		rad = wabs(a) * hu + wabs(b) * hw;
		return (lo > rad) || (hi < -rad);
	endfunction

	function automatic bit predict_overlap(atov_pkg::coord_t v[9]);
		wide_t h[3], d[3][3], e[3][3], du[3], dw[3], n[3], vlo[3], vhi[3];
		wide_t lo, hi, dot_lo, dot_hi, lo_c, hi_c, vx;
		int u, w;
		bit sep;
		sep = 0;
		for (int k = 0; k < 3; k++) begin
			lo_c = box_lo[k];
			hi_c = box_hi[k];
			h[k] = hi_c - lo_c;
			for (int i = 0; i < 3; i++) begin
				vx = v[i*3+k];
				d[i][k] = 2 * vx - (lo_c + hi_c);
			end
		end
		for (int k = 0; k < 3; k++) begin
			e[0][k] = d[1][k] - d[0][k];
			e[1][k] = d[2][k] - d[1][k];
			e[2][k] = d[0][k] - d[2][k];
		end
		// edge cross axis tests, one per edge and box axis
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				u = (k + 1) % 3;
				w = (k + 2) % 3;
				for (int j = 0; j < 3; j++) begin
					du[j] = d[j][u];
					dw[j] = d[j][w];
				end
				if (edge_axis_cuts(e[i][w], e[i][u], du, dw, h[u], h[w])) sep = 1;
			end
		// box faces
		for (int k = 0; k < 3; k++) begin
			lo = d[0][k];
			hi = d[0][k];
			for (int i = 1; i < 3; i++) begin
				if (d[i][k] < lo) lo = d[i][k];
				if (d[i][k] > hi) hi = d[i][k];
			end
			if (lo > h[k] || hi < -h[k]) sep = 1;
		end
		// triangle plane; a zero normal leaves both dots at zero
		dot_lo = 0;
		dot_hi = 0;
		for (int k = 0; k < 3; k++) begin
			u = (k + 1) % 3;
			w = (k + 2) % 3;
			n[k] = e[0][u] * e[1][w] - e[0][w] * e[1][u];
			if (n[k] > 0) begin
				vlo[k] = -h[k] - d[0][k];
				vhi[k] = h[k] - d[0][k];
			end else begin
				vlo[k] = h[k] - d[0][k];
				vhi[k] = -h[k] - d[0][k];
			end
			dot_lo += n[k] * vlo[k];
			dot_hi += n[k] * vhi[k];
		end
		if (dot_lo > 0 || dot_hi < 0) sep = 1;
		return !sep;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// config write; only called with nothing in flight, caller drops cfg_valid
	task automatic write_box(atov_pkg::cfg_reg_t idx, atov_pkg::coord_t val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		case (idx)
			atov_pkg::REG_MIN_X: box_lo[0] = val;
			atov_pkg::REG_MIN_Y: box_lo[1] = val;
			atov_pkg::REG_MIN_Z: box_lo[2] = val;
			atov_pkg::REG_MAX_X: box_hi[0] = val;
			atov_pkg::REG_MAX_Y: box_hi[1] = val;
			atov_pkg::REG_MAX_Z: box_hi[2] = val;
			default: ;
		endcase
		box_writes++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_box(atov_pkg::coord_t lx, atov_pkg::coord_t ly,
			atov_pkg::coord_t lz, atov_pkg::coord_t hx, atov_pkg::coord_t hy,
			atov_pkg::coord_t hz);
		wait_idle();
		write_box(atov_pkg::REG_MIN_X, lx);
		write_box(atov_pkg::REG_MIN_Y, ly);
		write_box(atov_pkg::REG_MIN_Z, lz);
		write_box(atov_pkg::REG_MAX_X, hx);
		write_box(atov_pkg::REG_MAX_Y, hy);
		write_box(atov_pkg::REG_MAX_Z, hz);
		cfg_valid <= 1'b0;
	endtask

	// send one triangle word; expectation queued on accept
	task automatic send_triangle(atov_pkg::coord_t v[9]);
		bit ok;
		int gap;
		s_tvalid <= 1'b1;
		for (int i = 0; i < 9; i++) s_tdata[i*atov_pkg::CW +: atov_pkg::CW] <= v[i];
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		verdict_q.push_back(predict_overlap(v));
		tri_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic atov_pkg::coord_t near_coord(int span);
		return atov_pkg::coord_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic send_random(int count, int span);
		atov_pkg::coord_t v[9];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++)
				v[i] = ($urandom_range(0, 9) == 0) ? atov_pkg::coord_t'($urandom)
					: near_coord(span);
			send_triangle(v);
		end
	endtask

	task automatic send_uniform(atov_pkg::coord_t x);
		atov_pkg::coord_t v[9];
		foreach (v[i]) v[i] = x;
		send_triangle(v);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_box();
		// box is a single point at the origin after reset
		send_uniform('0);
		send_uniform(32'sh0001_0000);
		send_random(20, 4);
	endtask

	task automatic test_directed();
		atov_pkg::coord_t v[9];
		set_box(-32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000,
			32'sh1_0000);
		send_uniform(32'sh8000_0000);
		send_uniform(32'sh7fff_ffff);
		send_uniform(32'sh0000_8000);                 // degenerate, inside
		send_uniform(32'sh0001_0000);                 // degenerate, on the corner
		send_uniform(32'sh0001_0001);                 // degenerate, just outside
		// collinear triangle crossing the box
		v = '{-32'sh5_0000, 0, 0, 0, 0, 0, 32'sh5_0000, 0, 0};
		send_triangle(v);
		// large triangle slicing through the box
		v = '{-32'sh40_0000, -32'sh40_0000, 0, 32'sh40_0000, -32'sh40_0000, 0,
			0, 32'sh40_0000, 0};
		send_triangle(v);
		// plane touching a corner, then one cutting the corner off
		v = '{32'sh3_0000, 0, 0, 0, 32'sh3_0000, 0, 0, 0, 32'sh3_0000};
		send_triangle(v);
		v = '{32'sh1_8000, 0, 0, 0, 32'sh1_8000, 0, 0, 0, 32'sh1_8000};
		send_triangle(v);
		// mixed extremes
		v = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 0, 0, 32'sh7fff_ffff};
		send_triangle(v);
		// full-range box
		set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh7fff_ffff);
		send_uniform(32'sh8000_0000);
		send_uniform(32'sh7fff_ffff);
		send_triangle(v);
		// inverted box: minimum above maximum
		set_box(32'sh2_0000, 32'sh2_0000, 32'sh2_0000, -32'sh2_0000, -32'sh2_0000,
			-32'sh2_0000);
		send_uniform('0);
		send_uniform(32'sh3_0000);
		send_random(6, 32'sh4_0000);
		// indexes past the last register must be dropped
		wait_idle();
		write_box(atov_pkg::cfg_reg_t'(6), 32'sh7fff_ffff);
		write_box(atov_pkg::cfg_reg_t'(7), 32'sh8000_0000);
		cfg_valid <= 1'b0;
		send_uniform('0);
	endtask

	task automatic test_box_sweep();
		atov_pkg::coord_t lo[3], hi[3];
		int span;
		for (int phase = 0; phase < 16; phase++) begin
			no_gaps = (phase % 5 == 2);
			span = (phase % 3 == 0) ? 32'sh2_0000 : 32'sh10_0000;
			for (int k = 0; k < 3; k++) begin
				lo[k] = near_coord(span);
				hi[k] = lo[k] + atov_pkg::coord_t'($urandom_range(0, span));
				if (phase % 7 == 6)
					hi[k] = lo[k] - atov_pkg::coord_t'($urandom_range(0, span));
				if (phase == 9) begin
					lo[k] = atov_pkg::coord_t'($urandom);
					hi[k] = atov_pkg::coord_t'($urandom);
				end
			end
			set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
			send_random(50, 2 * span);
		end
		no_gaps = 0;
	endtask

	// ------------------------------------------------------------------
	// output side: ready pattern and verdict check
	// ------------------------------------------------------------------
	int stall_left = 0;
	always @(posedge clk) begin
		if (no_gaps) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b1;
		end
	end

	// sampled mid-cycle; the word moves at the following rising edge
	always @(negedge clk) begin
		bit want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("overlap: verdict %0d with no triangle pending", m_tdata[0]);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want) begin
					$error("overlap: expected %0d, got %0d", want, m_tdata[0]);
					errors++;
				end
				if (m_tdata[7:1] !== 7'd0) begin
					$error("pad: expected 0, got %0h", m_tdata[7:1]);
					errors++;
				end
			end
			verdicts_seen++;
			hits_seen += m_tdata[0];
		end
	end

	// stall watchdog on all three channels
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_CYCLES) begin
			$display("watchdog: no word moved in %0d cycles", WATCHDOG_CYCLES);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		foreach (box_lo[k]) begin
			box_lo[k] = '0;
			box_hi[k] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_box();
		test_directed();
		test_box_sweep();
		wait_idle();
		$display("covered %0d triangles over %0d box writes; %0d verdicts, %0d overlapping",
			tri_sent, box_writes, verdicts_seen, hits_seen);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d verdicts missing", errors, verdict_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
